### rtl/nrmc_pkg.sv
// ---------------------------------------------------------------------------
// nrmc_pkg
// Shared types and constants of the RMC position parser.
// ---------------------------------------------------------------------------
`default_nettype none

package nrmc_pkg;

  localparam int DEG_W  = 10;
  localparam int MIN_W  = 7;
  localparam int FRAC_W = 14;
  localparam int POS_W  = 4;
  localparam int CNT_W  = 3;
  localparam int HPOS_W = 3;
  localparam int SEC_W  = 6;
  localparam int MAG_W  = 22;
  localparam int LAT_W  = 20;
  localparam int LON_W  = 23;
  localparam int Z_W    = 15;
  localparam int PROD_W = 32;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [HPOS_W-1:0] HDR_LAST = 3'd6;

  localparam logic [CNT_W-1:0] CNT_AFTER_HDR = 3'd1;
  localparam logic [CNT_W-1:0] CNT_LAT_COMMA = 3'd2;
  localparam logic [CNT_W-1:0] CNT_IN_LAT    = 3'd3;
  localparam logic [CNT_W-1:0] CNT_LON_COMMA = 3'd4;
  localparam logic [CNT_W-1:0] CNT_IN_LON    = 3'd5;
  localparam logic [CNT_W-1:0] CNT_MAX       = 3'd7;

  localparam int DEG_SCALE = 3600;
  localparam int MIN_SCALE = 60;
  // floor(z / 500) = (z * SEC_RECIP) >> SEC_SHIFT, exact for z < 30000
  localparam int SEC_RECIP = 67109;
  localparam int SEC_SHIFT = 25;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_SCAN,
    PH_FIELD,
    PH_STOP
  } phase_t;

  typedef struct packed {
    logic              commit;
    logic              is_lon;
    logic              negative;
    logic [DEG_W-1:0]  deg;
    logic [MIN_W-1:0]  minutes;
    logic [FRAC_W-1:0] frac;
    logic              fin;
    logic              ok;
  } fix_rec_t;

  typedef struct packed {
    logic             commit;
    logic             is_lon;
    logic             negative;
    logic [MAG_W-1:0] whole;
    logic [SEC_W-1:0] sec;
    logic             fin;
    logic             ok;
  } conv_rec_t;

endpackage

`default_nettype wire

### rtl/nrmc_ifs.sv
// ---------------------------------------------------------------------------
// nrmc_ifs
// Valid/ready channels: sentence bytes in, position words out.
// ---------------------------------------------------------------------------
`default_nettype none

interface nrmc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_sentence;

  modport source (output valid, output data_byte, output end_of_sentence, input ready);
  modport sink   (input valid, input data_byte, input end_of_sentence, output ready);
endinterface

interface nrmc_fix_if;
  logic                               valid;
  logic                               ready;
  logic                               ok;
  logic signed [nrmc_pkg::LAT_W-1:0]  latitude_arcsec;
  logic signed [nrmc_pkg::LON_W-1:0]  longitude_arcsec;

  modport source (output valid, output ok, output latitude_arcsec, output longitude_arcsec,
                  input ready);
  modport sink   (input valid, input ok, input latitude_arcsec, input longitude_arcsec,
                  output ready);
endinterface

`default_nettype wire

### rtl/nrmc_parser_top.sv
// ---------------------------------------------------------------------------
// nmea_rmc_position_parser
// The result word is registered after the edge that accepts the last byte of a
// sentence, through the scanner record and then the two conversion stages.
// Throughput: one byte per cycle; input stalls only when a second finished
// sentence meets a result word that has not been taken yet.
// Reset: synchronous, clears scanner state, stage valids and held coordinates.
// ---------------------------------------------------------------------------
`default_nettype none

module nmea_rmc_position_parser (
  input  wire logic  clk,
  input  wire logic  rst,
  nrmc_byte_if.sink  sentence,
  nrmc_fix_if.source position
);
  import nrmc_pkg::*;

  fix_rec_t rec_q;
  logic     rec_valid;
  logic     rec_ready;

  nrmc_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .sentence  (sentence),
    .rec_q     (rec_q),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready)
  );

  nrmc_converter u_converter (
    .clk       (clk),
    .rst       (rst),
    .rec_q     (rec_q),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .position  (position)
  );

endmodule

`default_nettype wire

### rtl/nrmc_parser.sv
// ---------------------------------------------------------------------------
// nrmc_parser
// Per-byte sentence scanner: header match, comma count, field digit
// accumulation. Emits a record on field completion and on end of sentence.
// ---------------------------------------------------------------------------
`default_nettype none

module nrmc_parser (
  input  wire logic          clk,
  input  wire logic          rst,
  nrmc_byte_if.sink          sentence,
  output nrmc_pkg::fix_rec_t rec_q,
  output logic               rec_valid,
  input  wire logic          rec_ready
);
  import nrmc_pkg::*;

  phase_t              phase, phase_next;
  logic [HPOS_W-1:0]   header_pos, header_pos_next;
  logic [CNT_W-1:0]    comma_count, comma_count_next;
  logic [POS_W-1:0]    field_pos, field_pos_next;
  logic                negative, negative_next;
  logic [DEG_W-1:0]    degree_acc, degree_acc_next;
  logic [MIN_W-1:0]    minute_acc, minute_acc_next;
  logic [FRAC_W-1:0]   fraction_acc, fraction_acc_next;
  logic                rejected, rejected_next;
  fix_rec_t            rec;
  logic                accept;

  function automatic logic [7:0] hdr_char(input logic [HPOS_W-1:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = 8'h24;
      3'd1:    ch = 8'h47;
      3'd2:    ch = 8'h50;
      3'd3:    ch = 8'h52;
      3'd4:    ch = 8'h4D;
      3'd5:    ch = 8'h43;
      3'd6:    ch = 8'h2C;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  assign sentence.ready = !rec_valid || rec_ready;
  assign accept         = sentence.valid && sentence.ready;

  always_comb begin
    logic [7:0]       c;
    logic             is_lon;
    logic [POS_W-1:0] nd;
    logic             is_digit;
    logic [3:0]       digit;
    logic             stepped;

    phase_next        = phase;
    header_pos_next   = header_pos;
    comma_count_next  = comma_count;
    field_pos_next    = field_pos;
    negative_next     = negative;
    degree_acc_next   = degree_acc;
    minute_acc_next   = minute_acc;
    fraction_acc_next = fraction_acc;
    rejected_next     = rejected;
    rec               = '0;

    c        = sentence.data_byte;
    is_lon   = (comma_count == CNT_IN_LON);
    nd       = is_lon ? 4'd3 : 4'd2;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    digit    = c[3:0];
    stepped  = 1'b0;

    case (phase)
      PH_HEADER: begin
        if (header_pos <= HDR_LAST && c == hdr_char(header_pos)) begin
          if (header_pos == HDR_LAST) begin
            header_pos_next  = '0;
            comma_count_next = CNT_AFTER_HDR;
            phase_next       = PH_SCAN;
          end else begin
            header_pos_next = header_pos + 1'b1;
          end
        end else begin
          rejected_next = 1'b1;
          phase_next    = PH_STOP;
        end
      end
      PH_SCAN: begin
        if (c == CH_NL) begin
          phase_next = PH_STOP;
        end else if (c == CH_COMMA) begin
          if (comma_count == CNT_LAT_COMMA || comma_count == CNT_LON_COMMA) begin
            field_pos_next    = '0;
            negative_next     = 1'b0;
            degree_acc_next   = '0;
            minute_acc_next   = '0;
            fraction_acc_next = '0;
            phase_next        = PH_FIELD;
          end
          if (comma_count != CNT_MAX) begin
            comma_count_next = comma_count + 1'b1;
          end
        end
      end
      PH_FIELD: begin
        if (c == CH_NL) begin
          rejected_next = 1'b1;
          phase_next    = PH_STOP;
        end else if (field_pos == '0 && !negative && c == CH_MINUS) begin
          negative_next = 1'b1;
        end else if (field_pos == nd + 4'd2) begin
          field_pos_next = field_pos + 1'b1;
          stepped        = 1'b1;
        end else if (is_digit) begin
          if (field_pos < nd) begin
            degree_acc_next = DEG_W'(degree_acc * DEG_W'(10) + DEG_W'(digit));
          end else if (field_pos < nd + 4'd2) begin
            minute_acc_next = MIN_W'(minute_acc * MIN_W'(10) + MIN_W'(digit));
          end else begin
            fraction_acc_next = FRAC_W'(fraction_acc * FRAC_W'(10) + FRAC_W'(digit));
          end
          field_pos_next = field_pos + 1'b1;
          stepped        = 1'b1;
        end else begin
          rejected_next = 1'b1;
          phase_next    = PH_STOP;
        end
        if (stepped && field_pos_next == nd + 4'd7) begin
          rec.commit        = 1'b1;
          rec.is_lon        = is_lon;
          rec.negative      = negative;
          rec.deg           = degree_acc_next;
          rec.minutes       = minute_acc_next;
          rec.frac          = fraction_acc_next;
          field_pos_next    = '0;
          negative_next     = 1'b0;
          degree_acc_next   = '0;
          minute_acc_next   = '0;
          fraction_acc_next = '0;
          phase_next        = PH_SCAN;
        end
      end
      default: begin
      end
    endcase

    if (sentence.end_of_sentence) begin
      rec.fin = 1'b1;
      rec.ok  = !rejected_next && phase_next != PH_HEADER && phase_next != PH_FIELD;
      phase_next        = PH_HEADER;
      header_pos_next   = '0;
      comma_count_next  = '0;
      field_pos_next    = '0;
      negative_next     = 1'b0;
      degree_acc_next   = '0;
      minute_acc_next   = '0;
      fraction_acc_next = '0;
      rejected_next     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      header_pos   <= '0;
      comma_count  <= '0;
      field_pos    <= '0;
      negative     <= 1'b0;
      degree_acc   <= '0;
      minute_acc   <= '0;
      fraction_acc <= '0;
      rejected     <= 1'b0;
      rec_valid    <= 1'b0;
    end else begin
      if (accept) begin
        phase        <= phase_next;
        header_pos   <= header_pos_next;
        comma_count  <= comma_count_next;
        field_pos    <= field_pos_next;
        negative     <= negative_next;
        degree_acc   <= degree_acc_next;
        minute_acc   <= minute_acc_next;
        fraction_acc <= fraction_acc_next;
        rejected     <= rejected_next;
      end
      if (accept && (rec.commit || rec.fin)) begin
        rec_valid <= 1'b1;
      end else if (rec_ready) begin
        rec_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (rec.commit || rec.fin)) begin
      rec_q <= rec;
    end
  end

  a_field_comma: assert property (@(posedge clk) disable iff (rst)
    phase == PH_FIELD |-> comma_count == CNT_IN_LAT || comma_count == CNT_IN_LON)
    else $error("field phase outside a coordinate field");

  a_hdr_idle: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SCAN || phase == PH_FIELD |-> header_pos == '0)
    else $error("header position left nonzero");

  a_eos_clear: assert property (@(posedge clk) disable iff (rst)
    accept && sentence.end_of_sentence |=> phase == PH_HEADER && comma_count == '0)
    else $error("state not cleared after end of sentence");

endmodule

`default_nettype wire

### rtl/nrmc_converter.sv
// ---------------------------------------------------------------------------
// nrmc_converter
// Two-stage arc-second conversion of committed fields, coordinate holding
// registers and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module nrmc_converter (
  input  wire logic          clk,
  input  wire logic          rst,
  input  nrmc_pkg::fix_rec_t rec_q,
  input  wire logic          rec_valid,
  output logic               rec_ready,
  nrmc_fix_if.source         position
);
  import nrmc_pkg::*;

  conv_rec_t          conv, conv_q;
  logic               conv_valid;
  logic               conv_go;
  logic               out_free;
  logic [Z_W-1:0]     frac3;
  logic [PROD_W-1:0]  sec_prod;
  logic [MAG_W-1:0]   mag;
  logic [LON_W-1:0]   value;
  logic [LAT_W-1:0]   lat_q, lat_next;
  logic [LON_W-1:0]   lon_q, lon_next;
  logic               out_valid;
  logic               out_ok;
  logic [LAT_W-1:0]   out_lat;
  logic [LON_W-1:0]   out_lon;

  // stage 1: degrees and minutes scaled, seconds = floor(frac * 3 / 500)
  always_comb begin
    frac3    = Z_W'({1'b0, rec_q.frac}) + Z_W'({rec_q.frac, 1'b0});
    sec_prod = PROD_W'(frac3) * PROD_W'(SEC_RECIP);
    conv.commit   = rec_q.commit;
    conv.is_lon   = rec_q.is_lon;
    conv.negative = rec_q.negative;
    conv.whole    = MAG_W'(rec_q.deg) * MAG_W'(DEG_SCALE)
                  + MAG_W'(rec_q.minutes) * MAG_W'(MIN_SCALE);
    conv.sec      = sec_prod[SEC_SHIFT +: SEC_W];
    conv.fin      = rec_q.fin;
    conv.ok       = rec_q.ok;
  end

  // stage 2: sum, sign, update coordinates
  always_comb begin
    mag      = conv_q.whole + MAG_W'(conv_q.sec);
    value    = conv_q.negative ? LON_W'(-{1'b0, mag}) : LON_W'({1'b0, mag});
    lat_next = (conv_q.commit && !conv_q.is_lon) ? value[LAT_W-1:0] : lat_q;
    lon_next = (conv_q.commit &&  conv_q.is_lon) ? value : lon_q;
  end

  assign out_free  = !out_valid || position.ready;
  assign conv_go   = conv_valid && (!conv_q.fin || out_free);
  assign rec_ready = !conv_valid || conv_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      conv_valid <= 1'b0;
      out_valid  <= 1'b0;
      lat_q      <= '0;
      lon_q      <= '0;
    end else begin
      if (rec_ready) begin
        conv_valid <= rec_valid;
      end
      if (conv_go) begin
        if (conv_q.fin) begin
          lat_q <= '0;
          lon_q <= '0;
        end else begin
          lat_q <= lat_next;
          lon_q <= lon_next;
        end
      end
      if (conv_go && conv_q.fin) begin
        out_valid <= 1'b1;
      end else if (position.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rec_ready) begin
      conv_q <= conv;
    end
    if (conv_go && conv_q.fin) begin
      out_ok  <= conv_q.ok;
      out_lat <= conv_q.ok ? lat_next : '0;
      out_lon <= conv_q.ok ? lon_next : '0;
    end
  end

  assign position.valid            = out_valid;
  assign position.ok               = out_ok;
  assign position.latitude_arcsec  = out_lat;
  assign position.longitude_arcsec = out_lon;

  a_fin_clears: assert property (@(posedge clk) disable iff (rst)
    conv_go && conv_q.fin |=> lat_q == '0 && lon_q == '0)
    else $error("coordinates kept across sentences");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    conv_go && conv_q.fin && !conv_q.ok |=>
      out_valid && !out_ok && out_lat == '0 && out_lon == '0)
    else $error("rejected sentence reported nonzero position");

endmodule

`default_nettype wire
